// File: rtl/fir32lp_pkg.sv
// shared constants and coefficient table for the fir32 low-pass filter
package fir32lp_pkg;

    localparam int DEF_TAP_COUNT    = 32;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH       = 16;
    localparam int FRAC_BITS        = 15;
    localparam int COEF_TABLE_LEN   = 32;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    // symmetric low-pass, q1.15
    localparam t_coef COEF_TABLE [COEF_TABLE_LEN] = '{
          16'sd30,   16'sd59,   16'sd89,  16'sd101,   16'sd54,  -16'sd87, -16'sd318, -16'sd571,
        -16'sd708, -16'sd560,   16'sd10, 16'sd1036, 16'sd2409, 16'sd3880, 16'sd5123, 16'sd5836,
         16'sd5836, 16'sd5123, 16'sd3880, 16'sd2409, 16'sd1036,  16'sd10, -16'sd560, -16'sd708,
        -16'sd571, -16'sd318,  -16'sd87,   16'sd54,  16'sd101,   16'sd89,   16'sd59,   16'sd30
    };

    // taps beyond the table carry zero weight
    function automatic t_coef coef_at(input int k);
        t_coef c;
        c = '0;
        if (k >= 0 && k < COEF_TABLE_LEN) begin
            c = COEF_TABLE[k];
        end
        return c;
    endfunction

endpackage

// File: rtl/fir32lp_tap_cell.sv
// one tap cell of the transposed-form chain: multiply by a fixed weight, add neighbor
module fir32lp_tap_cell
    import fir32lp_pkg::*;
#(
    parameter int    SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int    ACC_WIDTH    = DEF_SAMPLE_WIDTH + COEF_WIDTH + 5,
    parameter t_coef COEF         = '0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [ACC_WIDTH-1:0]    i_sum,
    output logic signed [ACC_WIDTH-1:0]    o_sum
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;

    logic signed [PROD_WIDTH-1:0] w_prod;
    logic signed [ACC_WIDTH-1:0]  r_sum;
    logic signed [ACC_WIDTH-1:0]  n_sum;

    assign w_prod = PROD_WIDTH'(i_sample) * PROD_WIDTH'(COEF);
    assign n_sum  = ACC_WIDTH'(w_prod) + i_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: rtl/fir32lp_out_stage.sv
// scale, saturate and optionally invert the filter sum; holds the result beat
module fir32lp_out_stage
    import fir32lp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int ACC_WIDTH    = DEF_SAMPLE_WIDTH + COEF_WIDTH + 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [ACC_WIDTH-1:0]    i_acc,
    input  logic                           i_invert,
    output logic                           o_take,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_sample
);

    localparam logic signed [ACC_WIDTH-1:0] SAT_POS =
        ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_NEG = -SAT_POS;
    localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
        ACC_WIDTH'((64'sd1 <<< FRAC_BITS) - 64'sd1);

    logic signed [ACC_WIDTH-1:0]    w_adj;
    logic signed [ACC_WIDTH-1:0]    w_quot;
    logic signed [ACC_WIDTH-1:0]    w_sat;
    logic signed [ACC_WIDTH-1:0]    w_final;
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;

    // bias negative sums so the arithmetic shift truncates toward zero
    assign w_adj  = i_acc[ACC_WIDTH-1] ? (i_acc + ROUND_BIAS) : i_acc;
    assign w_quot = w_adj >>> FRAC_BITS;

    always_comb begin
        if (w_quot > SAT_POS) begin
            w_sat = SAT_POS;
        end else if (w_quot < SAT_NEG) begin
            w_sat = SAT_NEG;
        end else begin
            w_sat = w_quot;
        end
    end

    assign w_final = i_invert ? -w_sat : w_sat;
    assign o_take  = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_sample <= w_final[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_left_sample  = r_sample;
    assign o_right_sample = r_sample;

endmodule

// File: rtl/fir32_lowpass_to_pcm16_stereo.sv
// top level: 32-tap symmetric low-pass fir with duplicated pcm16 stereo output
//
// Low-pass FIR (fc 4 kHz at 44.1 kHz) on a mono signed sample stream, giving
// the same saturated PCM sample on left and right. It takes one input beat per
// clock and returns exactly one result beat per input beat, in order. The
// filter is built in transposed form as a chain of tap cells: each cell holds
// one partial sum, multiplies the incoming sample by its fixed weight and adds
// the partial sum of its neighbor, so the whole chain advances by one sample
// on each accepted beat and the tap-0 cell ends up holding the exact wide sum.
// From input beat to result valid a sample passes the cell chain register
// and then the scale/saturate stage register, which also decouples the
// two sides. Throughput is one beat per clock as long as the output side takes
// results; when it stalls, two beats are buffered before o_ready drops. The
// sum is shifted right by 15 with truncation toward zero, clamped to
// +/-(2^(SAMPLE_WIDTH-1)-1), and negated when invert_polarity is set. Reset
// clears the history (all partial sums) and the polarity bit. invert_polarity
// should only be written when no beat is in flight.
module fir32_lowpass_to_pcm16_stereo
    import fir32lp_pkg::*;
#(
    parameter int TAP_COUNT    = DEF_TAP_COUNT,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_invert_polarity,
    // input sample channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_sample
);

    // room for the full product plus growth over all taps
    localparam int ACC_WIDTH = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAP_COUNT) + 1;

    logic                        r_invert;
    logic                        r_acc_valid;
    logic                        w_accept;
    logic                        w_take;
    logic signed [ACC_WIDTH-1:0] w_sum [TAP_COUNT+1];

    // config is always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
        end else if (i_cfg_valid) begin
            r_invert <= i_cfg_invert_polarity;
        end
    end

    // the tap-0 cell doubles as the sum register; it may be overwritten only
    // when its current content is empty or moves on this clock
    assign o_ready  = !r_acc_valid || w_take;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
        end else if (w_accept) begin
            r_acc_valid <= 1'b1;
        end else if (w_take) begin
            r_acc_valid <= 1'b0;
        end
    end

    // end of the chain feeds zero into the oldest tap
    assign w_sum[TAP_COUNT] = '0;

    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
        fir32lp_tap_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .ACC_WIDTH    (ACC_WIDTH),
            .COEF         (coef_at(k))
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_accept),
            .i_sample (i_sample_in),
            .i_sum    (w_sum[k+1]),
            .o_sum    (w_sum[k])
        );
    end

    fir32lp_out_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_acc_valid),
        .i_acc          (w_sum[0]),
        .i_invert       (r_invert),
        .o_take         (w_take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

endmodule
